[sv/wfsa_pkg.sv]
// Package for the worst-fit segment allocator: shared types, codes and constants.
// Used by wfsa_cell and worst_fit_segment_allocator; depends on nothing.
package wfsa_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int HEAP_BYTES       = 65536;
   localparam logic [16:0] HEAP_MAX = 17'(HEAP_BYTES);

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_FIND,
      S_MERGE_NEXT,
      S_MERGE_PREV
   } state_type;

   typedef enum logic [2:0] {
      C_HOLD,
      C_CLEAR,
      C_MARK,
      C_FREE,
      C_SPLIT,
      C_MERGE
   } cell_op_type;

   // One table entry. An entry with zero length is unused.
   typedef struct packed {
      logic [15:0] start;
      logic [16:0] len;
      logic        used;
   } seg_type;

   // Command broadcast to every cell.
   typedef struct packed {
      cell_op_type op;
      logic [16:0] size;
      logic [15:0] where;
      logic [16:0] heap;
   } cmd_type;

endpackage

[sv/wfsa_cell.sv]
// One cell of the segment chain: holds one table entry and one stage of the
// worst-fit search token. Depends on wfsa_pkg.
module wfsa_cell #(
   parameter int MAX_SEGMENTS = wfsa_pkg::MAX_SEGMENTS_DEF,
   parameter int K            = 0,
   localparam int IW          = $clog2(MAX_SEGMENTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  wfsa_pkg::cmd_type   cmd,
   input  logic [IW-1:0]       cmd_idx,
   input  wfsa_pkg::seg_type   left,
   input  wfsa_pkg::seg_type   right,
   output wfsa_pkg::seg_type   seg,
   input  logic                tok_found_in,
   input  logic [16:0]         tok_len_in,
   input  logic [IW-1:0]       tok_idx_in,
   input  logic [15:0]         tok_start_in,
   output logic                tok_found_out,
   output logic [16:0]         tok_len_out,
   output logic [IW-1:0]       tok_idx_out,
   output logic [15:0]         tok_start_out,
   output logic                hit,
   output logic                pair
);
   import wfsa_pkg::*;

   localparam logic [IW:0]   KI = (IW+1)'(K);
   localparam logic [IW-1:0] KS = IW'(K);

   seg_type       seg_ff, seg_in;
   logic          found_ff, found_in;
   logic [16:0]   len_ff, len_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [15:0]   start_ff, start_in;
   logic          cand, take;

   always_comb begin
      seg_in = seg_ff;
      case (cmd.op)
         C_CLEAR: begin
            seg_in.start = '0;
            seg_in.len   = (K == 0) ? cmd.heap : '0;
            seg_in.used  = 1'b0;
         end
         C_MARK: begin
            if (cmd_idx == KS) seg_in.used = 1'b1;
         end
         C_FREE: begin
            if (cmd_idx == KS) seg_in.used = 1'b0;
         end
         C_SPLIT: begin
            if (cmd_idx == KS) begin
               seg_in.len  = cmd.size;
               seg_in.used = 1'b1;
            end else if (KI == {1'b0, cmd_idx} + 1'b1) begin
               seg_in.start = 16'(left.start + cmd.size);
               seg_in.len   = left.len - cmd.size;
               seg_in.used  = 1'b0;
            end else if (KI > {1'b0, cmd_idx} + 1'b1) begin
               seg_in = left;
            end
         end
         C_MERGE: begin
            if (cmd_idx == KS) begin
               seg_in.len = seg_ff.len + right.len;
            end else if (KI > {1'b0, cmd_idx}) begin
               seg_in = right;
            end
         end
         default: seg_in = seg_ff;
      endcase
   end

   // Search stage: keep the longest fitting free entry, earliest on a tie.
   always_comb begin
      cand     = (seg_ff.len != '0) && !seg_ff.used && (seg_ff.len >= cmd.size);
      take     = cand && (!tok_found_in || (seg_ff.len > tok_len_in));
      found_in = tok_found_in || cand;
      len_in   = take ? seg_ff.len   : tok_len_in;
      idx_in   = take ? KS           : tok_idx_in;
      start_in = take ? seg_ff.start : tok_start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff.start <= '0;
         seg_ff.len   <= (K == 0) ? HEAP_MAX : '0;
         seg_ff.used  <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         seg_ff   <= seg_in;
         found_ff <= found_in;
      end
      len_ff   <= len_in;
      idx_ff   <= idx_in;
      start_ff <= start_in;
   end

   assign seg           = seg_ff;
   assign tok_found_out = found_ff;
   assign tok_len_out   = len_ff;
   assign tok_idx_out   = idx_ff;
   assign tok_start_out = start_ff;
   assign hit  = (seg_ff.len != '0) && (seg_ff.start == cmd.where);
   assign pair = (seg_ff.len != '0) && !seg_ff.used && (right.len != '0) && !right.used;

endmodule

[sv/worst_fit_segment_allocator.sv]
// Top level of the worst-fit segment allocator: control sequencer and the
// chain of wfsa_cell entries. Depends on wfsa_pkg and wfsa_cell.
//
//   channel   ports                                         handshake
//   request   req_func, req_request_size, req_block_start   start, busy
//   response  rsp_status, rsp_start_index                   rsp_valid (strobe)
//   config    csr_wdata                                     csr_we
//
// An allocate scans while the search token walks the cell chain one cell per
// cycle; the split or mark then happens in S_ALLOC, and the response follows.
// A free runs through lookup and mark, merge with the next entry, merge with
// the previous entry, then the response.
// A free whose start matches no entry answers straight from the lookup.
// Reset is synchronous and rebuilds the table as one free segment covering
// the whole heap; csr_we while idle does the same with the csr_wdata size.
// busy is high while a request is in flight. The response is a one-cycle
// strobe and cannot be held off by the receiver.
module worst_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = wfsa_pkg::MAX_SEGMENTS_DEF,
   localparam int IW          = $clog2(MAX_SEGMENTS),
   localparam int CW          = $clog2(MAX_SEGMENTS + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [16:0] req_request_size,
   input  logic [15:0] req_block_start,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_start_index,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);
   import wfsa_pkg::*;

   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SEGMENTS);

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  scan_ff, scan_in;
   logic [16:0]    size_ff, size_in;
   logic [15:0]    where_ff, where_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [15:0]    rsp_start_ff, rsp_start_in;

   cmd_type        cmd;
   logic [IW-1:0]  cmd_idx;
   logic [16:0]    heap_clamped;

   seg_type        segs [MAX_SEGMENTS];
   logic           tok_found [MAX_SEGMENTS+1];
   logic [16:0]    tok_len   [MAX_SEGMENTS+1];
   logic [IW-1:0]  tok_idx   [MAX_SEGMENTS+1];
   logic [15:0]    tok_start [MAX_SEGMENTS+1];
   logic [MAX_SEGMENTS-1:0] hits, pairs;
   logic [IW-1:0]  hit_idx;
   logic           any_hit;

   assign tok_found[0] = 1'b0;
   assign tok_len[0]   = '0;
   assign tok_idx[0]   = '0;
   assign tok_start[0] = '0;

   // The cell chain: each cell sees its neighbors' entries for shifting.
   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      seg_type left_seg, right_seg;
      if (k == 0) begin : g_first
         assign left_seg = '0;
      end else begin : g_left
         assign left_seg = segs[k-1];
      end
      if (k == MAX_SEGMENTS - 1) begin : g_last
         assign right_seg = '0;
      end else begin : g_right
         assign right_seg = segs[k+1];
      end
      wfsa_cell #(.MAX_SEGMENTS(MAX_SEGMENTS), .K(k)) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .cmd_idx       (cmd_idx),
         .left          (left_seg),
         .right         (right_seg),
         .seg           (segs[k]),
         .tok_found_in  (tok_found[k]),
         .tok_len_in    (tok_len[k]),
         .tok_idx_in    (tok_idx[k]),
         .tok_start_in  (tok_start[k]),
         .tok_found_out (tok_found[k+1]),
         .tok_len_out   (tok_len[k+1]),
         .tok_idx_out   (tok_idx[k+1]),
         .tok_start_out (tok_start[k+1]),
         .hit           (hits[k]),
         .pair          (pairs[k])
      );
   end

   // Segment starts are unique, so at most one cell hits; OR the indexes.
   always_comb begin
      hit_idx = '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         if (hits[k]) hit_idx = hit_idx | IW'(k);
      end
      any_hit = |hits;
   end

   // A written size of zero counts as one; anything larger than the heap
   // saturates to the heap.
   always_comb begin
      if (csr_wdata == '0) heap_clamped = 17'd1;
      else if (csr_wdata > HEAP_MAX) heap_clamped = HEAP_MAX;
      else heap_clamped = csr_wdata;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = (req_func == FUNC_FREE) ? S_FIND : S_SCAN;
         end
         S_SCAN: begin
            if (scan_ff == COUNT_MAX) state_in = S_ALLOC;
         end
         S_ALLOC:      state_in = S_IDLE;
         S_FIND:       state_in = any_hit ? S_MERGE_NEXT : S_IDLE;
         S_MERGE_NEXT: state_in = S_MERGE_PREV;
         S_MERGE_PREV: state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // Outputs: cell commands, bookkeeping and the response.
   always_comb begin
      cmd.op        = C_HOLD;
      cmd.size      = size_ff;
      cmd.where     = where_ff;
      cmd.heap      = heap_clamped;
      cmd_idx       = idx_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      size_in       = size_ff;
      where_in      = where_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_start_in  = '0;
      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               cmd.op   = C_CLEAR;
               count_in = CW'(1);
            end
            if (start) begin
               size_in  = req_request_size;
               where_in = req_block_start;
               scan_in  = '0;
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
         end
         S_ALLOC: begin
            rsp_valid_in = 1'b1;
            cmd_idx      = tok_idx[MAX_SEGMENTS];
            if (size_ff == '0 || !tok_found[MAX_SEGMENTS]) begin
               rsp_status_in = ST_NOFIT;
            end else if (tok_len[MAX_SEGMENTS] == size_ff) begin
               cmd.op       = C_MARK;
               rsp_start_in = tok_start[MAX_SEGMENTS];
            end else if (count_ff == COUNT_MAX) begin
               rsp_status_in = ST_FULL;
            end else begin
               cmd.op       = C_SPLIT;
               count_in     = count_ff + 1'b1;
               rsp_start_in = tok_start[MAX_SEGMENTS];
            end
         end
         S_FIND: begin
            idx_in  = hit_idx;
            cmd_idx = hit_idx;
            if (any_hit) begin
               cmd.op = C_FREE;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOTFOUND;
            end
         end
         S_MERGE_NEXT: begin
            if (pairs[idx_ff]) begin
               cmd.op   = C_MERGE;
               count_in = count_ff - 1'b1;
            end
         end
         S_MERGE_PREV: begin
            cmd_idx      = idx_ff - 1'b1;
            rsp_valid_in = 1'b1;
            if (idx_ff != '0 && pairs[idx_ff - 1'b1]) begin
               cmd.op   = C_MERGE;
               count_in = count_ff - 1'b1;
            end
         end
         default: cmd.op = C_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CW'(1);
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff       <= size_in;
      where_ff      <= where_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_index = rsp_start_ff;

endmodule
